// ===== sv/rc_receiver_frame_decoder_top_assert.svh =====
// Assertion macros for the RC receiver frame decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RC_RECEIVER_FRAME_DECODER_TOP_ASSERT_SVH
`define RC_RECEIVER_FRAME_DECODER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define RCFD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define RCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rcfd_pkg.sv =====
// Shared types and constants for the RC receiver frame decoder.
// No dependencies.
package rcfd_pkg;

    localparam logic [7:0] HDR_SYNC = 8'h20;
    localparam logic [7:0] HDR_TYPE = 8'h40;

    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW    = 5;
    localparam int HALF_DEPTH  = STORE_DEPTH / 2;
    localparam int HALF_AW     = STORE_AW - 1;

    localparam logic [3:0]  NARROW_CHANNELS = 4'd4;
    localparam logic [16:0] CENTER_NARROW   = 17'd1500;
    localparam logic [16:0] CENTER_WIDE     = 17'd1000;
    localparam logic [16:0] SPAN_NARROW     = 17'd500;
    localparam logic [16:0] SPAN_WIDE       = 17'd1000;
    localparam logic [14:0] Q_ONE           = 15'd16384;
    // ceil(2^28 / 125): exact floor division for numerators below 2^21
    localparam logic [21:0] RECIP_125       = 22'd2147484;
    localparam int          RECIP_SHIFT     = 28;

    typedef enum logic [1:0] {
        REG_LINK_SW  = 2'd0,
        REG_RESYNC   = 2'd1,
        REG_DISCONN  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_TYPE = 2'd1,
        PH_BODY = 2'd2
    } sync_phase_t;

    typedef enum logic [1:0] {
        JOB_STATUS    = 2'd0,
        JOB_LINK_DROP = 2'd1,
        JOB_DECODE    = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic      valid;
        job_kind_t kind;
    } job_slot_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

    typedef enum logic [2:0] {
        BK_IDLE     = 3'd0,
        BK_LINK_RD  = 3'd1,
        BK_LINK_CHK = 3'd2,
        BK_CH_RD    = 3'd3,
        BK_CH_PREP  = 3'd4,
        BK_CH_MUL   = 3'd5,
        BK_CH_EMIT  = 3'd6
    } back_state_t;

endpackage

// ===== sv/rc_receiver_frame_decoder_top.sv =====
// Top level of the RC receiver frame decoder: config registers, front end,
// job queue, frame store and back end. Depends on rcfd_pkg and the submodules.
//
//  port group   direction  handshake             payload
//  in           sink       in_valid / in_stall   cmd, data_byte
//  out          source     out_valid / out_stall kind, channel_index, raw_value,
//                                                scaled_value, link_connected, last
//  cfg          sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A byte or tick is taken and queued in the same cycle; the back end loads its
// status beat into the result register, one beat per cycle while out_stall is low.
// A completed frame holds off input until its last channel is in the result
// register: the back end takes the job, reads and checks the link switch, then
// runs each channel through store read, prep, multiply and emit in the one shared
// scaler, and holds in emit while out_stall is high.
// Reset needs no clearing pass; the frame store is written before it is read.
// cfg_ready is always high; writes take effect on the next cycle.
module rc_receiver_frame_decoder_top import rcfd_pkg::*; #(
    parameter int NUM_CHANNELS = 14,
    parameter int FRAME_BYTES  = 32,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [3:0]         channel_index,
    output logic [15:0]        raw_value,
    output logic signed [15:0] scaled_value,
    output logic               link_connected,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

`include "rc_receiver_frame_decoder_top_assert.svh"

    logic [3:0]  link_sw_reg;
    logic [15:0] resync_reg;
    logic [15:0] disconn_reg;

    logic               q_full;
    logic               q_push;
    job_kind_t          q_job;
    logic               q_pop;
    job_slot_t          q_head;
    store_wr_t          store_wr;
    logic               decode_done;
    logic               decode_busy;
    logic [HALF_AW-1:0] rd_addr;
    logic [7:0]         rd_even;
    logic [7:0]         rd_odd;

    logic               status_clean;
    logic               scaled_in_range;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_sw_reg <= 4'd7;
            resync_reg  <= 16'd10;
            disconn_reg <= 16'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LINK_SW: link_sw_reg <= cfg_data[3:0];
                REG_RESYNC:  resync_reg  <= cfg_data;
                REG_DISCONN: disconn_reg <= cfg_data;
                default:     link_sw_reg <= link_sw_reg;
            endcase
        end
    end

    rcfd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .cmd                   (cmd),
        .data_byte             (data_byte),
        .resync_timeout_ms     (resync_reg),
        .disconnect_timeout_ms (disconn_reg),
        .q_full                (q_full),
        .q_push                (q_push),
        .q_job                 (q_job),
        .store_wr              (store_wr),
        .decode_done           (decode_done),
        .decode_busy           (decode_busy)
    );

    rcfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .job_in (q_job),
        .pop    (q_pop),
        .full   (q_full),
        .head   (q_head)
    );

    // even bytes and odd bytes in separate banks: one channel word per read
    rcfd_ram #(
        .WIDTH (8),
        .DEPTH (HALF_DEPTH)
    ) u_store_even (
        .clk   (clk),
        .we    (store_wr.en && !store_wr.addr[0]),
        .waddr (store_wr.addr[STORE_AW-1:1]),
        .wdata (store_wr.data),
        .raddr (rd_addr),
        .rdata (rd_even)
    );

    rcfd_ram #(
        .WIDTH (8),
        .DEPTH (HALF_DEPTH)
    ) u_store_odd (
        .clk   (clk),
        .we    (store_wr.en && store_wr.addr[0]),
        .waddr (store_wr.addr[STORE_AW-1:1]),
        .wdata (store_wr.data),
        .raddr (rd_addr),
        .rdata (rd_odd)
    );

    rcfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (q_head),
        .q_pop               (q_pop),
        .link_switch_channel (link_sw_reg),
        .rd_addr             (rd_addr),
        .rd_even             (rd_even),
        .rd_odd              (rd_odd),
        .decode_done         (decode_done),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .kind                (kind),
        .channel_index       (channel_index),
        .raw_value           (raw_value),
        .scaled_value        (scaled_value),
        .link_connected      (link_connected),
        .last                (last)
    );

    assign status_clean    = last && (channel_index == 4'd0) && (raw_value == 16'd0)
                             && (scaled_value == 16'sd0);
    assign scaled_in_range = (scaled_value <= 16'sd16384) && (scaled_value >= -16'sd16384);

    `RCFD_ASSERT_IMP(a_store_frozen, decode_busy, in_stall, "input taken while frame is decoding")
    `RCFD_ASSERT_IMP(a_status_shape, out_valid && !kind, status_clean, "malformed status beat")
    `RCFD_ASSERT_IMP(a_scaled_range, out_valid && kind, scaled_in_range, "scaled value out of range")
    `RCFD_ASSERT_NEXT(a_done_releases, decode_done, !decode_busy, "frame store not released")

endmodule

// ===== sv/rcfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rcfd_queue.sv =====
// Job queue between the byte front end and the result back end.
// Depends on rcfd_pkg.
module rcfd_queue import rcfd_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_kind_t job_in,
    input  logic      pop,
    output logic      full,
    output job_slot_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    job_kind_t         slot_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.kind  = slot_reg[rd_ptr_reg];

endmodule

// ===== sv/rcfd_front.sv =====
// Front end: takes bytes and ticks, tracks frame sync and idle time,
// writes the frame store and queues one job per input. Depends on rcfd_pkg.
module rcfd_front import rcfd_pkg::*; #(
    parameter int FRAME_BYTES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    input  logic [15:0] resync_timeout_ms,
    input  logic [15:0] disconnect_timeout_ms,
    input  logic        q_full,
    output logic        q_push,
    output job_kind_t   q_job,
    output store_wr_t   store_wr,
    input  logic        decode_done,
    output logic        decode_busy
);

    localparam logic [5:0] END_POS = 6'(FRAME_BYTES);

    sync_phase_t phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic [15:0] idle_reg, idle_next;
    logic        busy_reg, busy_next;

    logic        accept;
    logic [15:0] idle_inc;
    logic [5:0]  pos_inc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = q_full || busy_reg;
    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign pos_inc  = pos_reg + 6'd1;

    // sync state, position and idle counter
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        idle_next  = idle_reg;
        if (accept)
        begin
            if (cmd)
            begin
                idle_next = idle_inc;
                if (idle_inc > resync_timeout_ms)
                begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                end
            end
            else
            begin
                idle_next = '0;
                case (phase_reg)
                    PH_TYPE:
                    begin
                        if (data_byte == HDR_TYPE)
                        begin
                            phase_next = PH_BODY;
                            pos_next   = 6'd2;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_BODY:
                    begin
                        pos_next = pos_inc;
                        if (pos_inc >= END_POS)
                        begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end
                    end
                    default:
                    begin
                        if (data_byte == HDR_SYNC)
                        begin
                            phase_next = PH_TYPE;
                            pos_next   = 6'd1;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                endcase
            end
        end
    end

    // queue push, job kind and store write
    always_comb
    begin
        q_push        = accept;
        q_job         = JOB_STATUS;
        store_wr.en   = 1'b0;
        store_wr.addr = pos_reg[STORE_AW-1:0];
        store_wr.data = data_byte;
        if (accept)
        begin
            if (cmd)
            begin
                if (idle_inc > disconnect_timeout_ms)
                begin
                    q_job = JOB_LINK_DROP;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_TYPE:
                    begin
                        store_wr.en   = (data_byte == HDR_TYPE);
                        store_wr.addr = STORE_AW'(1);
                    end
                    PH_BODY:
                    begin
                        store_wr.en = 1'b1;
                        if (pos_inc >= END_POS)
                        begin
                            q_job = JOB_DECODE;
                        end
                    end
                    default:
                    begin
                        store_wr.en   = (data_byte == HDR_SYNC);
                        store_wr.addr = '0;
                    end
                endcase
            end
        end
    end

    // store stays frozen until the back end has read the whole frame
    always_comb
    begin
        busy_next = busy_reg;
        if (q_push && q_job == JOB_DECODE)
        begin
            busy_next = 1'b1;
        end
        else if (decode_done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            idle_reg  <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            idle_reg  <= idle_next;
            busy_reg  <= busy_next;
        end
    end

    assign decode_busy = busy_reg;

endmodule

// ===== sv/rcfd_back.sv =====
// Back end: runs queued jobs, owns the link flag, reads channel words
// from the frame store, scales them and drives the result register.
// Depends on rcfd_pkg.
module rcfd_back import rcfd_pkg::*; #(
    parameter int NUM_CHANNELS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  job_slot_t           head,
    output logic                q_pop,
    input  logic [3:0]          link_switch_channel,
    output logic [HALF_AW-1:0]  rd_addr,
    input  logic [7:0]          rd_even,
    input  logic [7:0]          rd_odd,
    output logic                decode_done,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [3:0]          channel_index,
    output logic [15:0]         raw_value,
    output logic signed [15:0]  scaled_value,
    output logic                link_connected,
    output logic                last
);

    localparam logic [3:0] LAST_CH  = 4'(NUM_CHANNELS - 1);
    localparam logic [3:0] NUM_CH_L = 4'(NUM_CHANNELS);

    back_state_t state_reg, state_next;

    logic        link_reg, link_next;
    logic [3:0]  ch_reg, ch_next;
    logic        out_valid_reg;

    logic [15:0] raw_reg;
    logic        neg_reg;
    logic        clamp_reg;
    logic [21:0] num_reg;
    logic [43:0] prod_reg;

    logic        kind_reg;
    logic [3:0]  ch_out_reg;
    logic [15:0] raw_out_reg;
    logic [15:0] scaled_reg;
    logic        link_out_reg;
    logic        last_reg;

    logic        out_free;
    logic        load_status;
    logic        load_chan;
    logic [15:0] word;
    logic        narrow;
    logic [16:0] diff;
    logic [16:0] mag;
    logic [14:0] quot;
    logic [14:0] mag_q;
    logic [15:0] scaled;
    logic [16:0] sw_center;
    logic        sw_live;

    assign out_free = !out_valid_reg || !out_stall;
    assign word     = {rd_odd, rd_even};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid && head.kind == JOB_DECODE)
                begin
                    state_next = BK_LINK_RD;
                end
            end
            BK_LINK_RD:  state_next = BK_LINK_CHK;
            BK_LINK_CHK: state_next = BK_CH_RD;
            BK_CH_RD:    state_next = BK_CH_PREP;
            BK_CH_PREP:  state_next = BK_CH_MUL;
            BK_CH_MUL:   state_next = BK_CH_EMIT;
            BK_CH_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (ch_reg == LAST_CH) ? BK_IDLE : BK_CH_RD;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop       = 1'b0;
        load_status = 1'b0;
        load_chan   = 1'b0;
        rd_addr     = HALF_AW'(ch_reg + 4'd1);
        case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.kind == JOB_DECODE)
                    begin
                        q_pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        q_pop       = 1'b1;
                        load_status = 1'b1;
                    end
                end
            end
            BK_LINK_RD:
            begin
                rd_addr = HALF_AW'(link_switch_channel + 4'd1);
            end
            BK_CH_EMIT:
            begin
                load_chan = out_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    assign decode_done = load_chan && (ch_reg == LAST_CH);

    // a scaled value is zero exactly when the word sits on its center
    assign sw_center = (link_switch_channel < NARROW_CHANNELS) ? CENTER_NARROW : CENTER_WIDE;
    assign sw_live   = (link_switch_channel < NUM_CH_L) && ({1'b0, word} != sw_center);

    always_comb
    begin
        link_next = link_reg;
        if (load_status && head.kind == JOB_LINK_DROP)
        begin
            link_next = 1'b0;
        end
        else if (state_reg == BK_LINK_CHK)
        begin
            link_next = sw_live;
        end
    end

    always_comb
    begin
        ch_next = ch_reg;
        if (state_reg == BK_LINK_CHK)
        begin
            ch_next = '0;
        end
        else if (load_chan)
        begin
            ch_next = ch_reg + 4'd1;
        end
    end

    // scaling: |d| * 2^k / 125, k = 12 for narrow channels, 11 otherwise
    assign narrow = (ch_reg < NARROW_CHANNELS);
    assign diff   = narrow ? (CENTER_NARROW - {1'b0, word}) : ({1'b0, word} - CENTER_WIDE);
    assign mag    = diff[16] ? (17'd0 - diff) : diff;
    assign quot   = prod_reg[RECIP_SHIFT +: 15];
    assign mag_q  = clamp_reg ? Q_ONE : quot;
    assign scaled = neg_reg ? (16'd0 - {1'b0, mag_q}) : {1'b0, mag_q};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            link_reg      <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            link_reg  <= link_next;
            ch_reg    <= ch_next;
            if (load_status || load_chan)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_CH_PREP)
        begin
            raw_reg   <= word;
            neg_reg   <= diff[16];
            clamp_reg <= (mag >= (narrow ? SPAN_NARROW : SPAN_WIDE));
            num_reg   <= narrow ? {mag[9:0], 12'd0} : {1'b0, mag[9:0], 11'd0};
        end
        if (state_reg == BK_CH_MUL)
        begin
            prod_reg <= num_reg * RECIP_125;
        end
        if (load_status)
        begin
            kind_reg     <= 1'b0;
            ch_out_reg   <= '0;
            raw_out_reg  <= '0;
            scaled_reg   <= '0;
            link_out_reg <= link_next;
            last_reg     <= 1'b1;
        end
        else if (load_chan)
        begin
            kind_reg     <= 1'b1;
            ch_out_reg   <= ch_reg;
            raw_out_reg  <= raw_reg;
            scaled_reg   <= scaled;
            link_out_reg <= link_reg;
            last_reg     <= (ch_reg == LAST_CH);
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign channel_index  = ch_out_reg;
    assign raw_value      = raw_out_reg;
    assign scaled_value   = scaled_reg;
    assign link_connected = link_out_reg;
    assign last           = last_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for rc_receiver_frame_decoder_top: byte/tick stimulus,
// a cycle-free decoder predictor and a beat-by-beat output check.
// Depends on rcfd_pkg and the RTL under sv/.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rcfd_pkg::*;

    localparam int NUM_CH       = 14;
    localparam int FRAME_LEN    = 32;
    localparam int NARROW_CHANS = 4;
    localparam longint NARROW_MID  = 1500;
    localparam longint NARROW_SPAN = 500;
    localparam longint WIDE_MID    = 1000;
    localparam longint WIDE_SPAN   = 1000;
    localparam longint Q14_ONE     = 16384;
    localparam int RUN_LIMIT_NS    = 2_000_000;

    localparam logic CMD_BYTE     = 1'b0;
    localparam logic CMD_TICK     = 1'b1;
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_CHANNEL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [3:0]         ch;
        logic [15:0]        raw;
        logic signed [15:0] scaled;
        logic               link;
        logic               last;
    } beat_t;

    typedef struct {
        logic       c;
        logic [7:0] b;
        bit         typed;
        beat_t      exp;
    } dir_row_t;

    typedef logic [15:0] chan_set_t [NUM_CH];

    // status beat with the link down, as seen before any frame has completed
    localparam beat_t STATUS_DOWN = '{KIND_STATUS, 4'd0, 16'd0, 16'sd0, 1'b0, 1'b1};

    localparam logic [15:0] RAW_CORNERS [13] = '{
        16'd0, 16'd1, 16'd999, 16'd1000, 16'd1001, 16'd1499, 16'd1500,
        16'd1501, 16'd2000, 16'd2001, 16'h7FFF, 16'h8000, 16'hFFFF
    };

    logic               clk;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic               cmd            = CMD_BYTE;
    logic [7:0]         data_byte      = 8'h00;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic               kind;
    logic [3:0]         channel_index;
    logic [15:0]        raw_value;
    logic signed [15:0] scaled_value;
    logic               link_connected;
    logic               last;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index      = REG_LINK_SW;
    logic [15:0]        cfg_data       = 16'h0000;

    rc_receiver_frame_decoder_top u_top (.*);

    // decoder state as the predictor sees it
    sync_phase_t rx_phase    = PH_HUNT;
    logic [5:0]  rx_pos      = 6'd0;
    logic [7:0]  frame_mem [FRAME_LEN];
    logic [15:0] idle_count  = 16'd0;
    logic        link_flag   = 1'b0;
    logic [3:0]  sw_chan     = 4'd7;
    logic [15:0] resync_ms   = 16'd10;
    logic [15:0] drop_ms     = 16'd100;

    beat_t pending_beats [$];
    int    items_sent  = 0;
    int    beats_seen  = 0;
    int    frames_seen = 0;
    int    errors      = 0;
    int    hold_cycles = 0;
    int    burst_left  = 0;
    bit    pace_on     = 1'b1;
    bit    stall_on    = 1'b1;

    dir_row_t dir_rows [15] = '{
        '{CMD_TICK, 8'h00, 1'b1, STATUS_DOWN},  // tick straight out of reset
        '{CMD_BYTE, 8'h00, 1'b1, STATUS_DOWN},
        '{CMD_BYTE, 8'hFF, 1'b1, STATUS_DOWN},
        '{CMD_BYTE, 8'h40, 1'b1, STATUS_DOWN},  // type byte with no header
        '{CMD_BYTE, 8'h20, 1'b1, STATUS_DOWN},
        '{CMD_BYTE, 8'h20, 1'b0, STATUS_DOWN},  // header twice: back to hunt
        '{CMD_BYTE, 8'h20, 1'b0, STATUS_DOWN},
        '{CMD_BYTE, 8'h00, 1'b0, STATUS_DOWN},
        '{CMD_BYTE, 8'h20, 1'b0, STATUS_DOWN},
        '{CMD_BYTE, 8'h40, 1'b0, STATUS_DOWN},
        '{CMD_BYTE, 8'h20, 1'b0, STATUS_DOWN},  // header value as body data
        '{CMD_TICK, 8'hFF, 1'b0, STATUS_DOWN},  // short idle keeps the frame
        '{CMD_BYTE, 8'h40, 1'b0, STATUS_DOWN},
        '{CMD_BYTE, 8'hFF, 1'b0, STATUS_DOWN},
        '{CMD_BYTE, 8'h00, 1'b0, STATUS_DOWN}
    };

    function automatic logic [15:0] chan_raw(int ch);
        return {frame_mem[(3 + 2 * ch) % FRAME_LEN], frame_mem[(2 + 2 * ch) % FRAME_LEN]};
    endfunction

    // Q2.14, truncated toward zero, clamped to +/-1.0
    function automatic logic signed [15:0] chan_q14(int ch, logic [15:0] raw);
        longint q;
        if (ch < NARROW_CHANS)
            q = (NARROW_MID - longint'(raw)) * Q14_ONE / NARROW_SPAN;
        else
            q = (longint'(raw) - WIDE_MID) * Q14_ONE / WIDE_SPAN;
        if (q > Q14_ONE)
            q = Q14_ONE;
        if (q < -Q14_ONE)
            q = -Q14_ONE;
        return q[15:0];
    endfunction

    function automatic void decoder_step(logic c, logic [7:0] b);
        beat_t bt;
        logic signed [15:0] sw_q;
        bt = STATUS_DOWN;
        if (c == CMD_TICK)
        begin
            if (idle_count != 16'hFFFF)
                idle_count++;
            if (idle_count > drop_ms)
                link_flag = 1'b0;
            if (idle_count > resync_ms)
            begin
                rx_phase = PH_HUNT;
                rx_pos   = 6'd0;
            end
        end
        else
        begin
            idle_count = 16'd0;
            case (rx_phase)
                PH_TYPE:
                begin
                    if (b == HDR_TYPE)
                    begin
                        frame_mem[1] = b;
                        rx_phase     = PH_BODY;
                        rx_pos       = 6'd2;
                    end else
                        rx_phase = PH_HUNT;
                end
                PH_BODY:
                begin
                    frame_mem[rx_pos[4:0]] = b;
                    rx_pos = rx_pos + 6'd1;
                    if (rx_pos >= FRAME_LEN)
                    begin
                        sw_q = (sw_chan < NUM_CH) ? chan_q14(sw_chan, chan_raw(sw_chan)) : '0;
                        link_flag = (sw_q != 0);
                        rx_phase  = PH_HUNT;
                        rx_pos    = 6'd0;
                        frames_seen++;
                        for (int i = 0; i < NUM_CH; i++)
                        begin
                            bt.kind   = KIND_CHANNEL;
                            bt.ch     = 4'(i);
                            bt.raw    = chan_raw(i);
                            bt.scaled = chan_q14(i, bt.raw);
                            bt.link   = link_flag;
                            bt.last   = (i == NUM_CH - 1);
                            pending_beats.push_back(bt);
                        end
                        return;
                    end
                end
                default:
                begin
                    // the unused phase code behaves as hunting
                    if (b == HDR_SYNC)
                    begin
                        frame_mem[0] = b;
                        rx_phase     = PH_TYPE;
                        rx_pos       = 6'd1;
                    end else
                        rx_phase = PH_HUNT;
                end
            endcase
        end
        bt.link = link_flag;
        pending_beats.push_back(bt);
    endfunction

    task automatic send_item(logic c, logic [7:0] b, bit use_typed = 1'b0,
                             beat_t typed_exp = STATUS_DOWN);
        int gap;
        @(negedge clk);
        in_valid  = 1'b1;
        cmd       = c;
        data_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        decoder_step(c, b);
        if (use_typed)
            pending_beats[pending_beats.size() - 1] = typed_exp;
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                repeat (gap)
                begin
                    @(negedge clk);
                    in_valid  = 1'b0;
                    cmd       = 1'($urandom);
                    data_byte = 8'($urandom);
                end
                burst_left = $urandom_range(1, 12);
            end else
                burst_left--;
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n)
            send_item(CMD_TICK, 8'($urandom));
    endtask

    function automatic logic [7:0] frame_byte(chan_set_t v, int pos);
        if (pos == 0)
            return HDR_SYNC;
        if (pos == 1)
            return HDR_TYPE;
        if (pos < 2 + 2 * NUM_CH)
            return pos[0] ? v[(pos - 2) / 2][15:8] : v[(pos - 2) / 2][7:0];
        return 8'($urandom);  // checksum bytes, not checked by the block
    endfunction

    task automatic send_span(chan_set_t v, int from, int to);
        for (int p = from; p <= to; p++)
            send_item(CMD_BYTE, frame_byte(v, p));
    endtask

    function automatic void fill_random(output chan_set_t v);
        for (int i = 0; i < NUM_CH; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: v[i] = RAW_CORNERS[$urandom_range(0, 12)];
                8, 9:       v[i] = 16'($urandom);
                default:    v[i] = 16'($urandom_range(800, 2200));
            endcase
        end
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_LINK_SW: sw_chan   = val[3:0];
            REG_RESYNC:  resync_ms = val;
            REG_DISCONN: drop_ms   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_cfg(logic [15:0] sw, logic [15:0] rs, logic [15:0] dc);
        wait_drained();
        write_reg(REG_LINK_SW, sw);
        write_reg(REG_RESYNC, rs);
        write_reg(REG_DISCONN, dc);
    endtask

    // half well-formed frames, plus broken headers, cut frames, tick runs, noise
    task automatic run_traffic(int quota);
        int start;
        int sel;
        int cut;
        logic [7:0] b;
        chan_set_t vals;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            sel = $urandom_range(0, 99);
            fill_random(vals);
            if (sel < 50)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    cut = $urandom_range(2, FRAME_LEN - 2);
                    send_span(vals, 0, cut);
                    send_ticks($urandom_range(1, 4));
                    send_span(vals, cut + 1, FRAME_LEN - 1);
                end else
                    send_span(vals, 0, FRAME_LEN - 1);
            end
            else if (sel < 65)
            begin
                b = 8'($urandom);
                if (b == HDR_TYPE)
                    b = HDR_SYNC;
                send_span(vals, 0, 0);
                send_item(CMD_BYTE, b);
            end
            else if (sel < 75)
            begin
                send_span(vals, 0, $urandom_range(2, 20));
                send_ticks($urandom_range(1, 14));
            end
            else if (sel < 90)
            begin
                send_ticks($urandom_range(1, 12));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_item(CMD_BYTE, 8'($urandom));
            end
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
    endtask

    task automatic flag_field(string name, longint want, longint got);
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout with %0d beats still expected", pending_beats.size());
        $display("rc_receiver_frame_decoder_top: mismatch");
        $finish;
    end

    // receiver side: alternating stall and free runs, no stall when stall_on is clear, or a long hold-off on request
    initial
    begin
        bit stalling;
        int run_left;
        stalling = 1'b0;
        run_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else if (!stall_on)
            begin
                out_stall = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 7) : $urandom_range(1, 12);
                end
                out_stall = stalling;
                run_left--;
            end
        end
    end

    always @(posedge clk)
    begin : beat_check
        beat_t got;
        beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind, channel_index, raw_value, scaled_value, link_connected, last};
            beats_seen++;
            if (pending_beats.size() == 0)
            begin
                $display("%0t ns: unexpected beat, expected none, got %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got.kind !== want.kind)
                    flag_field("kind", want.kind, got.kind);
                if (got.ch !== want.ch)
                    flag_field("channel_index", want.ch, got.ch);
                if (got.raw !== want.raw)
                    flag_field("raw_value", want.raw, got.raw);
                if (got.scaled !== want.scaled)
                    flag_field("scaled_value", $signed(want.scaled), $signed(got.scaled));
                if (got.link !== want.link)
                    flag_field("link_connected", want.link, got.link);
                if (got.last !== want.last)
                    flag_field("last", want.last, got.last);
            end
        end
    end

    initial
    begin
        chan_set_t vals;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].c, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].exp);
        send_ticks(11);  // idle past the default resync time drops the partial frame

        // every scaling corner: clamps both ways, exact +/-1.0, zero, truncation
        vals = '{16'd0, 16'hFFFF, 16'd1500, 16'd2000, 16'd1000, 16'd2000, 16'd0,
                 16'hFFFF, 16'd1001, 16'd999, 16'd2001, 16'd1, 16'h8000, 16'h7FFF};
        send_span(vals, 0, FRAME_LEN - 1);

        // reset settings; receiver holds off long enough to back up the input
        wait_drained();
        hold_cycles = 250;
        run_traffic(16);

        // zero timeouts: every tick drops the link and any partial frame
        set_cfg(16'd0, 16'd0, 16'd0);
        pace_on  = 1'b0;
        stall_on = 1'b0;
        run_traffic(4);
        pace_on  = 1'b1;
        stall_on = 1'b1;

        set_cfg(16'd13, 16'd3, 16'd5);
        run_traffic(4);

        // switch channel beyond the last one: a frame always drops the link
        set_cfg(16'd15, 16'd1, 16'd2);
        run_traffic(4);

        // max timeouts never fire; a lowered disconnect time drops the link mid-frame
        set_cfg(16'd4, 16'hFFFF, 16'hFFFF);
        pace_on  = 1'b0;
        stall_on = 1'b0;
        fill_random(vals);
        vals[4] = 16'd2000;
        send_span(vals, 0, 3);
        send_ticks(6);
        wait_drained();
        write_reg(REG_DISCONN, 16'd6);
        send_item(CMD_TICK, 8'h00);
        send_span(vals, 4, FRAME_LEN - 1);
        pace_on  = 1'b1;
        stall_on = 1'b1;

        set_cfg(16'd14, 16'd2, 16'd1);
        run_traffic(4);

        wait_drained();
        repeat (80) @(posedge clk);
        $display("sent %0d bytes and ticks, %0d frames decoded, %0d beats checked",
                 items_sent, frames_seen, beats_seen);
        $display("six register settings incl. zero and max timeouts, link drop mid-frame");
        if (errors == 0)
            $display("rc_receiver_frame_decoder_top: match");
        else
            $display("rc_receiver_frame_decoder_top: mismatch");
        $finish;
    end

endmodule
